>>> sv/mmsa_pkg.sv
// Shared types and constants of the matrix multiply-add block.
`default_nettype none

package mmsa_pkg;

    localparam int MAT_DIM_DEF     = 384;
    localparam int SECRET_ROWS_DEF = 8;
    localparam int DATA_W          = 16;
    localparam int TYPE_W          = 2;
    localparam int KIDX_W          = 3;
    localparam int COL_W           = 9;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD_S   = 2'd0,
        REQ_LOAD_OUT = 2'd1,
        REQ_MAC      = 2'd2,
        REQ_READ     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_RD
    } t_state;

endpackage

`default_nettype wire

>>> sv/mmsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module mmsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

>>> sv/matrix_mul_add_sa_plus_e.sv
// Top level of the out += S*A modulo 2^16 multiply-accumulate engine.
`default_nettype none

// Usage. Load every S entry (type 0) and every initial out entry
// (type 1) first, then stream the A elements (type 2), then read out entries
// (type 3). S and out live in two memories of SECRET_ROWS*MAT_DIM 16-bit words
// each, with no reset and no clearing pass: read only entries you wrote.
// A multiply-accumulate runs one read-modify-write per row through the
// accumulator memory's single read port and a single 16x16 multiplier,
// then drains the multiply and add stages before another word is taken. A
// read waits for the output register to free; loads and multiply-accumulates
// go on while a read word waits to be taken.
// Out-of-range rows or columns: loads and multiply-accumulates are dropped,
// and a read returns zero.
module matrix_mul_add_sa_plus_e #(
    parameter int MAT_DIM     = mmsa_pkg::MAT_DIM_DEF,
    parameter int SECRET_ROWS = mmsa_pkg::SECRET_ROWS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [mmsa_pkg::TYPE_W-1:0] i_req_type,
    input  wire logic [mmsa_pkg::KIDX_W-1:0] i_k_index,
    input  wire logic [mmsa_pkg::COL_W-1:0]  i_j_index,
    input  wire logic [mmsa_pkg::COL_W-1:0]  i_i_index,
    input  wire logic [mmsa_pkg::DATA_W-1:0] i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [mmsa_pkg::DATA_W-1:0]      o_read_value
);

    localparam int DEPTH = SECRET_ROWS * MAT_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int RCW   = $clog2(SECRET_ROWS + 1);
    localparam int DW    = mmsa_pkg::DATA_W;

    mmsa_pkg::t_state r_state, n_state;
    mmsa_pkg::t_req   w_req;

    logic w_accept, w_k_ok, w_j_ok, w_i_ok, w_out_free;
    logic [AW-1:0] w_s_load_addr, w_acc_load_addr;

    // multiply-accumulate sequencing
    logic [RCW-1:0] r_row;
    logic [AW-1:0]  r_sa, r_aa, r_a1, r_a2;
    logic [DW-1:0]  r_val, r_prod, r_acc;
    logic           r_v1, r_v2;
    logic           w_issue, w_last;
    logic [2*DW-1:0] w_mult;

    // read path and output register
    logic          r_rd_ok;
    logic          r_out_valid;
    logic [DW-1:0] r_out_data;

    // memory ports
    logic          w_s_we, w_acc_we, w_acc_re;
    logic [AW-1:0] w_acc_waddr, w_acc_raddr;
    logic [DW-1:0] w_acc_wdata, w_s_q, w_acc_q;

    assign w_req      = mmsa_pkg::t_req'(i_req_type);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_k_ok     = 32'(i_k_index) < 32'(SECRET_ROWS);
    assign w_j_ok     = 32'(i_j_index) < 32'(MAT_DIM);
    assign w_i_ok     = 32'(i_i_index) < 32'(MAT_DIM);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = r_row == RCW'(SECRET_ROWS - 1);

    // row-major flat addresses; only meaningful when the indexes are in range
    assign w_s_load_addr   = AW'(i_k_index) * AW'(MAT_DIM) + AW'(i_j_index);
    assign w_acc_load_addr = AW'(i_k_index) * AW'(MAT_DIM) + AW'(i_i_index);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmsa_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_req == mmsa_pkg::REQ_MAC && w_j_ok && w_i_ok) begin
                        n_state = mmsa_pkg::S_MAC;
                    end else if (w_req == mmsa_pkg::REQ_READ) begin
                        n_state = mmsa_pkg::S_RD;
                    end
                end
            end
            mmsa_pkg::S_MAC: begin
                if (w_last) begin
                    n_state = mmsa_pkg::S_DRAIN;
                end
            end
            mmsa_pkg::S_DRAIN: begin
                // the final write-back lands on the edge that leaves this state
                if (!r_v1) begin
                    n_state = mmsa_pkg::S_IDLE;
                end
            end
            mmsa_pkg::S_RD: begin
                if (w_out_free) begin
                    n_state = mmsa_pkg::S_IDLE;
                end
            end
            default: n_state = mmsa_pkg::S_IDLE;
        endcase
    end

    // state outputs and memory port control
    always_comb begin
        o_in_stall  = 1'b1;
        w_issue     = 1'b0;
        w_s_we      = 1'b0;
        w_acc_we    = 1'b0;
        w_acc_waddr = r_a2;
        w_acc_wdata = r_acc + r_prod;
        w_acc_re    = 1'b0;
        w_acc_raddr = r_aa;
        case (r_state)
            mmsa_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                w_s_we      = w_accept && w_req == mmsa_pkg::REQ_LOAD_S && w_k_ok && w_j_ok;
                w_acc_we    = w_accept && w_req == mmsa_pkg::REQ_LOAD_OUT
                              && w_k_ok && w_i_ok;
                w_acc_waddr = w_acc_load_addr;
                w_acc_wdata = i_value;
                w_acc_re    = w_accept && w_req == mmsa_pkg::REQ_READ;
                w_acc_raddr = w_acc_load_addr;
            end
            mmsa_pkg::S_MAC: begin
                w_issue  = 1'b1;
                w_acc_re = 1'b1;
                w_acc_we = r_v2;
            end
            mmsa_pkg::S_DRAIN: begin
                w_acc_we = r_v2;
            end
            mmsa_pkg::S_RD: begin
                o_in_stall = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign w_mult = r_val * w_s_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmsa_pkg::S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            if (r_state == mmsa_pkg::S_RD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        // capture the element and the row-0 addresses at accept
        if (w_accept) begin
            r_row   <= '0;
            r_sa    <= AW'(i_j_index);
            r_aa    <= AW'(i_i_index);
            r_val   <= i_value;
            r_rd_ok <= w_k_ok && w_i_ok;
        end else if (w_issue) begin
            // advance one row: step both addresses by a full row
            if (!w_last) begin
                r_row <= r_row + RCW'(1);
            end
            r_sa <= r_sa + AW'(MAT_DIM);
            r_aa <= r_aa + AW'(MAT_DIM);
        end

        // multiply stage, then add and write back
        r_a1 <= r_aa;
        if (r_v1) begin
            r_prod <= w_mult[DW-1:0];
            r_acc  <= w_acc_q;
            r_a2   <= r_a1;
        end

        if (r_state == mmsa_pkg::S_RD && w_out_free) begin
            r_out_data <= r_rd_ok ? w_acc_q : '0;
        end
    end

    mmsa_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_secret_ram (
        .i_clk  (i_clk),
        .i_we   (w_s_we),
        .i_waddr(w_s_load_addr),
        .i_wdata(i_value),
        .i_re   (w_issue),
        .i_raddr(r_sa),
        .o_rdata(w_s_q)
    );

    mmsa_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_accum_ram (
        .i_clk  (i_clk),
        .i_we   (w_acc_we),
        .i_waddr(w_acc_waddr),
        .i_wdata(w_acc_wdata),
        .i_re   (w_acc_re),
        .i_raddr(w_acc_raddr),
        .o_rdata(w_acc_q)
    );

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_data;

    // no pipeline work may be in flight while new words are taken
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> o_in_stall)
        else $error("input taken while multiply-accumulate in flight");

    // the pipeline is drained whenever the sequencer is idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmsa_pkg::S_IDLE) |-> (!r_v1 && !r_v2))
        else $error("write-back pending in idle");

    // a read that finds the output register free presents its word next cycle
    a_read_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmsa_pkg::S_RD && w_out_free)
        |=> (o_out_valid && r_state == mmsa_pkg::S_IDLE))
        else $error("read word not presented");

    // row counter stays within the secret rows while rows are issued
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmsa_pkg::S_MAC) |-> (32'(r_row) < 32'(SECRET_ROWS)))
        else $error("row counter out of range");

endmodule

`default_nettype wire
